/* rtl/asr_pkg.sv */
`default_nettype none

package asr_pkg;

    localparam int SLOTS     = 256;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CMD_W     = 2;
    localparam int OWNER_W   = 22;
    localparam int TS_W      = 63;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_REGISTER = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_QUERY    = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic out_free;
    } ctrl_status_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [TS_W-1:0]    ts;
    } slot_t;

endpackage

`default_nettype wire

/* rtl/asr_ctrl.sv */
`default_nettype none

module asr_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  asr_pkg::ctrl_status_t status,
    output asr_pkg::ctrl_cmd_t   cmd
);

    asr_pkg::state_t state_reg;
    asr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            asr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = asr_pkg::ST_SCAN;
                end
            end
            asr_pkg::ST_SCAN: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = asr_pkg::ST_DRAIN;
                end
            end
            asr_pkg::ST_DRAIN: begin
                state_next = asr_pkg::ST_COMMIT;
            end
            asr_pkg::ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = asr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = asr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/asr_datapath.sv */
`default_nettype none

module asr_datapath (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  asr_pkg::ctrl_cmd_t               cmd,
    output asr_pkg::ctrl_status_t            status,
    input  wire [asr_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [asr_pkg::M_TDATA_W-1:0]    m_tdata
);

    asr_pkg::slot_t mem [asr_pkg::SLOTS];

    logic [asr_pkg::SLOTS-1:0]   valid_reg;
    logic [asr_pkg::CMD_W-1:0]   req_cmd_reg;
    logic [asr_pkg::OWNER_W-1:0] req_owner_reg;
    logic [asr_pkg::TS_W-1:0]    req_ts_reg;
    logic [asr_pkg::IDX_W-1:0]   addr_reg;
    logic                        rd_vld_reg;
    logic                        rd_valid_reg;
    logic [asr_pkg::IDX_W-1:0]   rd_idx_reg;
    asr_pkg::slot_t              rd_data_reg;
    logic                        match_found_reg;
    logic [asr_pkg::IDX_W-1:0]   match_idx_reg;
    logic                        free_found_reg;
    logic [asr_pkg::IDX_W-1:0]   free_idx_reg;
    logic                        any_reg;
    logic [asr_pkg::TS_W-1:0]    min_reg;
    logic                        m_tvalid_reg;
    logic [asr_pkg::TS_W-1:0]    out_ts_reg;
    logic                        out_done_reg;

    logic                        active;
    logic                        is_reg;
    logic                        is_clr;
    logic                        hit;
    logic                        reg_ok;
    logic                        clr_ok;
    logic [asr_pkg::IDX_W-1:0]   wr_idx;
    logic [asr_pkg::TS_W-1:0]    min_next;
    logic                        done_next;

    assign active = (req_owner_reg != '0);
    assign is_reg = active && (req_cmd_reg == asr_pkg::CMD_REGISTER);
    assign is_clr = active && (req_cmd_reg == asr_pkg::CMD_CLEAR);
    assign hit    = rd_valid_reg && (rd_data_reg.owner == req_owner_reg);

    assign reg_ok    = is_reg && (match_found_reg || free_found_reg);
    assign clr_ok    = is_clr && match_found_reg;
    assign wr_idx    = match_found_reg ? match_idx_reg : free_idx_reg;
    assign done_next = reg_ok || clr_ok;

    // This request's slot is left out of the scan minimum; a register folds it in here.
    always_comb begin
        if (reg_ok) begin
            min_next = (!any_reg || (req_ts_reg < min_reg)) ? req_ts_reg : min_reg;
        end else begin
            min_next = any_reg ? min_reg : '0;
        end
    end

    assign status.last_issue = (addr_reg == asr_pkg::IDX_W'(asr_pkg::SLOTS - 1));
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_done_reg, out_ts_reg};

    always_ff @(posedge aclk) begin
        rd_data_reg  <= mem[addr_reg];
        rd_valid_reg <= valid_reg[addr_reg];
        rd_idx_reg   <= addr_reg;
        if (cmd.commit && reg_ok) begin
            mem[wr_idx] <= '{owner: req_owner_reg, ts: req_ts_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_cmd_reg   <= s_tdata[asr_pkg::CMD_W-1:0];
            req_owner_reg <= s_tdata[asr_pkg::CMD_W +: asr_pkg::OWNER_W];
            req_ts_reg    <= s_tdata[asr_pkg::CMD_W + asr_pkg::OWNER_W +: asr_pkg::TS_W];
        end
        if (rd_vld_reg && rd_valid_reg && !((is_reg || is_clr) && hit)) begin
            if (!any_reg || (rd_data_reg.ts < min_reg)) begin
                min_reg <= rd_data_reg.ts;
            end
        end
        if (rd_vld_reg && hit && !match_found_reg) begin
            match_idx_reg <= rd_idx_reg;
        end
        if (rd_vld_reg && !rd_valid_reg && !free_found_reg) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit) begin
            out_ts_reg   <= min_next;
            out_done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            addr_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            any_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.issue;
            if (cmd.load) begin
                addr_reg        <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                any_reg         <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    addr_reg <= addr_reg + asr_pkg::IDX_W'(1);
                end
                if (rd_vld_reg && rd_valid_reg && !((is_reg || is_clr) && hit)) begin
                    any_reg <= 1'b1;
                end
                if (rd_vld_reg && hit) begin
                    match_found_reg <= 1'b1;
                end
                if (rd_vld_reg && !rd_valid_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.commit && reg_ok) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.commit && clr_ok) begin
                valid_reg[match_idx_reg] <= 1'b0;
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    a_commit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result committed while the output register is still held");

    a_clear_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && clr_ok) |=> !valid_reg[$past(match_idx_reg)])
        else $error("cleared slot is still marked occupied");

    a_register_fills_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && reg_ok) |=> valid_reg[$past(wr_idx)])
        else $error("registered slot is not marked occupied");

    a_read_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |=> rd_vld_reg)
        else $error("slot read issued without data returning");

endmodule

`default_nettype wire

/* rtl/active_snapshot_registry.sv */
`default_nettype none

// Registry of active snapshots: a table of asr_pkg::SLOTS owner/timestamp slots.
// Requests enter on the s_ stream: command 0 registers or refreshes the owner's
// timestamp, command 1 frees the owner's slot, command 2 only reads the table.
// Each request yields exactly one result on the m_ stream: the smallest timestamp
// among occupied slots after the request (zero for an empty table) and a done flag.
// A request walks every slot through the table's read port, one slot a cycle,
// then passes a drain state, where the last read returns, and a commit state that
// folds in its own update, writes back the table and loads the result.
// A new request is taken only after the commit, once the block is back in idle.
// The memory read port, one address a cycle, bounds the scan.
// Only one request is in flight; s_tready is high whenever the block is idle.
// The result waits in an output register; while the receiver stalls, the next
// request is accepted and scanned, and it waits before write-back until that
// register is taken.
// Reset clears all occupancy flags, so the table is empty and the
// block is ready as soon as reset is released.
module active_snapshot_registry (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // command [1:0], owner_id [23:2], snap_ts [86:24], zero pad [87]
    input  wire [asr_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // oldest_ts [62:0], done_res [63]
    output logic [asr_pkg::M_TDATA_W-1:0] m_tdata
);

    asr_pkg::ctrl_cmd_t    cmd;
    asr_pkg::ctrl_status_t status;

    asr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* tb/tb_active_snapshot_registry.sv */
`timescale 1ns / 1ps

module tb_active_snapshot_registry;

    localparam logic [asr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int POOL_SIZE    = 320;
    localparam int RANDOM_ITEMS = 1880;
    localparam logic [asr_pkg::TS_W-1:0]    TS_MAX    = {asr_pkg::TS_W{1'b1}};
    localparam logic [asr_pkg::OWNER_W-1:0] OWNER_MAX = {asr_pkg::OWNER_W{1'b1}};

    typedef struct packed {
        logic [asr_pkg::TS_W-1:0] oldest;
        logic                     done;
    } registry_result_t;

    typedef struct packed {
        logic [asr_pkg::CMD_W-1:0]   cmd;
        logic [asr_pkg::OWNER_W-1:0] owner;
        logic [asr_pkg::TS_W-1:0]    ts;
        logic                        known;
        logic [asr_pkg::TS_W-1:0]    exp_oldest;
        logic                        exp_done;
    } request_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [asr_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [asr_pkg::M_TDATA_W-1:0] m_tdata;

    logic [asr_pkg::OWNER_W-1:0] slot_owner_q [asr_pkg::SLOTS];
    logic [asr_pkg::TS_W-1:0]    slot_ts_q    [asr_pkg::SLOTS];
    logic [asr_pkg::OWNER_W-1:0] owner_pool   [POOL_SIZE];

    registry_result_t oldest_expected [$];
    request_row_t     directed_rows   [18];

    logic             req_taken;
    logic             cur_known;
    registry_result_t cur_typed;
    bit               idle_on;
    int               stall_left;
    int               quiet_cycles;
    int               errors;

    active_snapshot_registry dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    task automatic registry_step(input logic [asr_pkg::CMD_W-1:0] cmd,
                                 input logic [asr_pkg::OWNER_W-1:0] owner,
                                 input logic [asr_pkg::TS_W-1:0] ts,
                                 output registry_result_t res);
        int  free_idx;
        bit  hit;
        bit  any;
        logic [asr_pkg::TS_W-1:0] m;
        logic done;
        free_idx = -1;
        hit      = 1'b0;
        any      = 1'b0;
        m        = '0;
        done     = 1'b0;
        if (owner != '0) begin
            case (cmd)
                asr_pkg::CMD_REGISTER: begin
                    for (int i = 0; i < asr_pkg::SLOTS; i++) begin
                        if (!hit && slot_owner_q[i] == owner) begin
                            slot_ts_q[i] = ts;
                            hit = 1'b1;
                        end
                        if (free_idx < 0 && slot_owner_q[i] == '0) begin
                            free_idx = i;
                        end
                    end
                    if (hit) begin
                        done = 1'b1;
                    end else if (free_idx >= 0) begin
                        slot_owner_q[free_idx] = owner;
                        slot_ts_q[free_idx]    = ts;
                        done = 1'b1;
                    end
                end
                asr_pkg::CMD_CLEAR: begin
                    for (int i = 0; i < asr_pkg::SLOTS; i++) begin
                        if (!hit && slot_owner_q[i] == owner) begin
                            slot_owner_q[i] = '0;
                            slot_ts_q[i]    = '0;
                            hit = 1'b1;
                        end
                    end
                    done = hit;
                end
                default: ;
            endcase
        end
        for (int i = 0; i < asr_pkg::SLOTS; i++) begin
            if (slot_owner_q[i] != '0 && (!any || slot_ts_q[i] < m)) begin
                m   = slot_ts_q[i];
                any = 1'b1;
            end
        end
        res.oldest = m;
        res.done   = done;
    endtask

    // Request side: predict on every accepted request.
    always @(posedge aclk) begin
        registry_result_t res;
        if (aresetn && s_tvalid && s_tready) begin
            registry_step(s_tdata[asr_pkg::CMD_W-1:0],
                          s_tdata[asr_pkg::CMD_W+asr_pkg::OWNER_W-1:asr_pkg::CMD_W],
                          s_tdata[asr_pkg::CMD_W+asr_pkg::OWNER_W+asr_pkg::TS_W-1:
                                  asr_pkg::CMD_W+asr_pkg::OWNER_W], res);
            oldest_expected.push_back(cur_known ? cur_typed : res);
        end
        req_taken <= aresetn && s_tvalid && s_tready;
    end

    // Result side: compare against the oldest expectation.
    always @(posedge aclk) begin
        registry_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (oldest_expected.size() == 0) begin
                $display("%0t: unexpected result oldest_ts=%h done_res=%b",
                         $time, m_tdata[asr_pkg::TS_W-1:0], m_tdata[asr_pkg::TS_W]);
                errors++;
            end else begin
                want = oldest_expected.pop_front();
                if (m_tdata[asr_pkg::TS_W-1:0] !== want.oldest) begin
                    $display("%0t: oldest_ts mismatch expected=%h actual=%h",
                             $time, want.oldest, m_tdata[asr_pkg::TS_W-1:0]);
                    errors++;
                end
                if (m_tdata[asr_pkg::TS_W] !== want.done) begin
                    $display("%0t: done_res mismatch expected=%b actual=%b",
                             $time, want.done, m_tdata[asr_pkg::TS_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: short random stalls, now and then a long one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 6) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 299) == 0) ? $urandom_range(260, 300) : 0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [asr_pkg::TS_W-1:0] pick_ts();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 13) begin
            return TS_MAX;
        end else if (r < 35) begin
            return asr_pkg::TS_W'($urandom_range(0, 1000));
        end
        return asr_pkg::TS_W'({$urandom, $urandom});
    endfunction

    task automatic send_request(input logic [asr_pkg::CMD_W-1:0] cmd,
                                input logic [asr_pkg::OWNER_W-1:0] owner,
                                input logic [asr_pkg::TS_W-1:0] ts, input logic known,
                                input logic [asr_pkg::TS_W-1:0] exp_oldest,
                                input logic exp_done);
        if (idle_on && $urandom_range(0, 99) < 10) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 300)) @(negedge aclk);
        end
        s_tdata          = {1'b0, ts, owner, cmd};
        cur_known        = known;
        cur_typed.oldest = exp_oldest;
        cur_typed.done   = exp_done;
        s_tvalid         = 1'b1;
        do @(negedge aclk); while (!req_taken);
    endtask

    task automatic random_request(input int phase);
        int r;
        int pool_top;
        logic [asr_pkg::CMD_W-1:0]   cmd;
        logic [asr_pkg::OWNER_W-1:0] owner;
        r        = $urandom_range(0, 99);
        pool_top = (phase == 0) ? 23 : POOL_SIZE - 1;
        owner    = owner_pool[$urandom_range(0, pool_top)];
        case (phase)
            0:       cmd = (r < 50) ? asr_pkg::CMD_REGISTER
                         : (r < 80) ? asr_pkg::CMD_CLEAR : asr_pkg::CMD_QUERY;
            1:       cmd = (r < 90) ? asr_pkg::CMD_REGISTER
                         : (r < 95) ? asr_pkg::CMD_CLEAR : asr_pkg::CMD_QUERY;
            2:       cmd = (r < 45) ? asr_pkg::CMD_REGISTER
                         : (r < 90) ? asr_pkg::CMD_CLEAR : asr_pkg::CMD_QUERY;
            default: cmd = (r < 8)  ? asr_pkg::CMD_REGISTER
                         : (r < 93) ? asr_pkg::CMD_CLEAR : asr_pkg::CMD_QUERY;
        endcase
        r = $urandom_range(0, 99);
        if (r < 3) begin
            cmd = CMD_UNUSED;
        end else if (r < 6) begin
            owner = '0;
        end else if (r < 8) begin
            owner = asr_pkg::OWNER_W'($urandom);
        end
        send_request(cmd, owner, pick_ts(), 1'b0, '0, 1'b0);
    endtask

    initial begin
        int phase;
        errors       = 0;
        idle_on      = 1'b1;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cur_known    = 1'b0;
        cur_typed    = '0;
        req_taken    = 1'b0;
        stall_left   = 0;
        quiet_cycles = 0;
        for (int i = 0; i < asr_pkg::SLOTS; i++) begin
            slot_owner_q[i] = '0;
            slot_ts_q[i]    = '0;
        end
        // The low ten bits keep the pool entries distinct and nonzero.
        for (int i = 0; i < POOL_SIZE; i++) begin
            owner_pool[i] = {12'($urandom), 10'(i + 1)};
        end

        directed_rows = '{
            '{asr_pkg::CMD_QUERY,    22'd1,     63'd0,   1'b1, 63'd0,   1'b0},
            '{asr_pkg::CMD_CLEAR,    22'd5,     63'd0,   1'b1, 63'd0,   1'b0},
            '{asr_pkg::CMD_REGISTER, 22'd0,     63'd7,   1'b1, 63'd0,   1'b0},
            '{asr_pkg::CMD_REGISTER, OWNER_MAX, TS_MAX,  1'b1, TS_MAX,  1'b1},
            '{asr_pkg::CMD_REGISTER, 22'd1,     63'd0,   1'b1, 63'd0,   1'b1},
            '{CMD_UNUSED,            22'd1,     63'd9,   1'b1, 63'd0,   1'b0},
            '{asr_pkg::CMD_CLEAR,    22'd1,     63'd0,   1'b1, TS_MAX,  1'b1},
            '{asr_pkg::CMD_REGISTER, 22'd2,     63'd5,   1'b1, 63'd5,   1'b1},
            '{asr_pkg::CMD_REGISTER, 22'd2,     63'd100, 1'b1, 63'd100, 1'b1},
            '{asr_pkg::CMD_CLEAR,    22'd0,     63'd0,   1'b1, 63'd100, 1'b0},
            '{asr_pkg::CMD_CLEAR,    OWNER_MAX, 63'd0,   1'b1, 63'd100, 1'b1},
            '{asr_pkg::CMD_CLEAR,    22'd2,     63'd0,   1'b1, 63'd0,   1'b1},
            '{asr_pkg::CMD_REGISTER, 22'h155555, {32'h2AAAAAAA, 31'h2AAAAAAA},
              1'b0, 63'd0, 1'b0},
            '{asr_pkg::CMD_REGISTER, 22'h2AAAAA, {32'h55555555, 31'h55555555},
              1'b0, 63'd0, 1'b0},
            '{asr_pkg::CMD_QUERY,    22'h2AAAAA, TS_MAX, 1'b0, 63'd0,  1'b0},
            '{asr_pkg::CMD_REGISTER, 22'h155555, 63'd3,  1'b0, 63'd0,  1'b0},
            '{asr_pkg::CMD_CLEAR,    22'h155555, 63'd0,  1'b0, 63'd0,  1'b0},
            '{asr_pkg::CMD_CLEAR,    22'h2AAAAA, 63'd0,  1'b0, 63'd0,  1'b0}
        };

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].cmd, directed_rows[i].owner, directed_rows[i].ts,
                         directed_rows[i].known, directed_rows[i].exp_oldest,
                         directed_rows[i].exp_done);
        end

        // Small owner pool first, then filling the table until it is full,
        // then mixed traffic on the full pool, then mostly clears.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n < 500) ? 0 : (n < 1100) ? 1 : (n < 1500) ? 2 : 3;
            if (n == 500 || n == 1100) begin
                s_tvalid = 1'b0;
                while (oldest_expected.size() != 0) @(negedge aclk);
            end
            idle_on = !(n >= 600 && n < 900);
            random_request(phase);
        end
        s_tvalid = 1'b0;
        idle_on  = 1'b1;

        while (oldest_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
